// File: sv/naq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// naq_pkg
// Shared widths, constants and curve tables for the near-axis quotient unit.
// ----------------------------------------------------------------------------
package naq_pkg;

    localparam int unsigned COORD_W   = 24;
    localparam int unsigned MAG_W     = 24;
    localparam int unsigned PROD_W    = 48;
    localparam int unsigned QUO_W     = 24;
    localparam int unsigned CURVE_W   = 18;
    localparam int unsigned RES_W     = 9;
    localparam int unsigned THETA_W   = 24;
    localparam int unsigned DIV_STEPS = 24;
    localparam int unsigned X_W       = 36;

    localparam logic [THETA_W-1:0] THETA_RESET = 24'd24904;
    localparam logic [RES_W-1:0]   RES_ALIGNED = 9'd256;
    localparam logic [RES_W-1:0]   RES_ZERO    = 9'd0;

    localparam logic [10:0] RECIP_1000 = 11'd1048;
    localparam logic [9:0]  DIV_CONST  = 10'd1000;

    typedef logic [2:0] seg_t;

    localparam seg_t SEG_0 = 3'd0;
    localparam seg_t SEG_1 = 3'd1;
    localparam seg_t SEG_2 = 3'd2;
    localparam seg_t SEG_3 = 3'd3;
    localparam seg_t SEG_4 = 3'd4;

    typedef struct packed {
        logic             hit;
        logic [RES_W-1:0] val;
    } special_t;

    function automatic logic [CURVE_W-1:0] seg_q0(input seg_t s);
        logic [CURVE_W-1:0] r;
        unique case (s)
            SEG_0:   r = 18'd0;
            SEG_1:   r = 18'd16384;
            SEG_2:   r = 18'd32768;
            SEG_3:   r = 18'd65536;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] seg_k(input seg_t s);
        logic [4:0] r;
        unique case (s)
            SEG_0:   r = 5'd14;
            SEG_1:   r = 5'd14;
            SEG_2:   r = 5'd15;
            SEG_3:   r = 5'd16;
            default: r = 5'd17;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] seg_v0(input seg_t s);
        logic [9:0] r;
        unique case (s)
            SEG_0:   r = 10'd1000;
            SEG_1:   r = 10'd841;
            SEG_2:   r = 10'd707;
            SEG_3:   r = 10'd500;
            default: r = 10'd250;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] seg_dv(input seg_t s);
        logic [7:0] r;
        unique case (s)
            SEG_0:   r = 8'd159;
            SEG_1:   r = 8'd134;
            SEG_2:   r = 8'd207;
            SEG_3:   r = 8'd250;
            default: r = 8'd250;
        endcase
        return r;
    endfunction

endpackage

// File: sv/near_axis_quotient_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// near_axis_quotient_unit
// Throughput: one item per cycle; the 24-stage restoring divider sets depth.
// The whole pipeline holds while the output item waits on m_tready.
// Reset: synchronous active-low aresetn clears valid bits and sets theta to
// its default of 24904.
// ----------------------------------------------------------------------------
module near_axis_quotient_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // first_x, first_y, second_x, second_y
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // quotient, zero fill
);

    localparam int unsigned NST = 30;
    localparam int unsigned DS  = naq_pkg::DIV_STEPS;

    logic                          en;
    logic [NST-1:0]                vld_reg;
    logic [naq_pkg::THETA_W-1:0]   theta_reg;

    logic [naq_pkg::MAG_W-1:0]     along_reg, across_reg;
    logic [naq_pkg::PROD_W-1:0]    n_reg, d_reg;
    logic                          along0_reg, across0_reg;

    logic [naq_pkg::PROD_W-1:0]    div_r_reg [0:DS];
    logic [naq_pkg::PROD_W-1:0]    div_r_next [1:DS];
    logic [naq_pkg::PROD_W-1:0]    div_d_reg [0:DS];
    logic [naq_pkg::QUO_W-1:0]     div_q_reg [0:DS];
    logic [naq_pkg::QUO_W-1:0]     div_q_next [1:DS];
    naq_pkg::special_t             div_sp_reg [0:DS];
    naq_pkg::special_t             sp_next;

    logic [naq_pkg::CURVE_W-1:0]   y_reg, y_next;
    naq_pkg::special_t             seg_sp_reg;
    logic [naq_pkg::CURVE_W-1:0]   y2_reg;
    logic [naq_pkg::RES_W-1:0]     qa_reg, qa_next;
    naq_pkg::special_t             mul_sp_reg;
    logic [naq_pkg::RES_W-1:0]     res_reg, res_next;

    logic signed [24:0]            dx, dy;
    logic [naq_pkg::MAG_W-1:0]     ax, ay;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[NST-1];
    assign m_tdata   = {7'd0, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            theta_reg <= naq_pkg::THETA_RESET;
        end else if (cfg_valid) begin
            theta_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // stage 1: magnitudes
    always_comb begin
        dx = $signed({s_tdata[23], s_tdata[23:0]}) - $signed({s_tdata[71], s_tdata[71:48]});
        dy = $signed({s_tdata[47], s_tdata[47:24]}) - $signed({s_tdata[95], s_tdata[95:72]});
        ax = dx[24] ? 24'(-dx) : dx[23:0];
        ay = dy[24] ? 24'(-dy) : dy[23:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            along_reg  <= s_tuser ? ay : ax;
            across_reg <= s_tuser ? ax : ay;
        end
    end

    // stage 2: square and scaled divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg       <= 48'(along_reg * along_reg);
            d_reg       <= 48'(theta_reg * across_reg);
            along0_reg  <= (along_reg == '0);
            across0_reg <= (across_reg == '0);
        end
    end

    // stage 3: special cases
    always_comb begin
        sp_next.hit = along0_reg || across0_reg || ({n_reg, 6'd0} >= {6'd0, d_reg});
        sp_next.val = along0_reg ? naq_pkg::RES_ALIGNED : naq_pkg::RES_ZERO;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_r_reg[0]  <= n_reg;
            div_d_reg[0]  <= d_reg;
            div_q_reg[0]  <= '0;
            div_sp_reg[0] <= sp_next;
        end
    end

    // divider: one quotient bit per stage
    always_comb begin
        logic [naq_pkg::PROD_W:0] sh;
        for (int i = 1; i <= DS; i++) begin
            sh = {div_r_reg[i-1], 1'b0};
            if (sh >= {1'b0, div_d_reg[i-1]}) begin
                div_r_next[i] = 48'(sh - {1'b0, div_d_reg[i-1]});
                div_q_next[i] = {div_q_reg[i-1][naq_pkg::QUO_W-2:0], 1'b1};
            end else begin
                div_r_next[i] = sh[naq_pkg::PROD_W-1:0];
                div_q_next[i] = {div_q_reg[i-1][naq_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 1; i <= DS; i++) begin
                div_r_reg[i]  <= div_r_next[i];
                div_d_reg[i]  <= div_d_reg[i-1];
                div_q_reg[i]  <= div_q_next[i];
                div_sp_reg[i] <= div_sp_reg[i-1];
            end
        end
    end

    // curve segment: y = floor(X / 2^k), X = 256*(v0*l - t*dv) + 500*l
    always_comb begin
        logic [naq_pkg::CURVE_W-1:0] q;
        naq_pkg::seg_t               s;
        logic [naq_pkg::CURVE_W-1:0] t;
        logic [naq_pkg::X_W-1:0]     base;
        logic [naq_pkg::X_W-1:0]     x;
        logic [4:0]                  k;
        q = div_q_reg[DS][naq_pkg::CURVE_W-1:0];
        if (q < 18'd16384)       s = naq_pkg::SEG_0;
        else if (q < 18'd32768)  s = naq_pkg::SEG_1;
        else if (q < 18'd65536)  s = naq_pkg::SEG_2;
        else if (q < 18'd131072) s = naq_pkg::SEG_3;
        else                     s = naq_pkg::SEG_4;
        k    = naq_pkg::seg_k(s);
        t    = q - naq_pkg::seg_q0(s);
        base = (36'(naq_pkg::seg_v0(s)) * 36'd256 + 36'd500) << k;
        x    = base - ((36'(t) * 36'(naq_pkg::seg_dv(s))) << 8);
        y_next = 18'(x >> k);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg      <= y_next;
            seg_sp_reg <= div_sp_reg[DS];
        end
    end

    // reciprocal estimate of y / 1000, low by at most one
    always_comb begin
        logic [28:0] p;
        p       = 29'(y_reg) * 29'(naq_pkg::RECIP_1000);
        qa_next = p[28:20];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qa_reg     <= qa_next;
            y2_reg     <= y_reg;
            mul_sp_reg <= seg_sp_reg;
        end
    end

    always_comb begin
        logic [naq_pkg::CURVE_W-1:0] rem;
        rem = y2_reg - 18'(qa_reg * naq_pkg::DIV_CONST);
        if (mul_sp_reg.hit) begin
            res_next = mul_sp_reg.val;
        end else if (rem >= 18'(naq_pkg::DIV_CONST)) begin
            res_next = qa_reg + 9'd1;
        end else begin
            res_next = qa_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

endmodule
